// ===== src/tstg_pkg.sv =====
// ----------------------------------------------------------------------------
// tstg_pkg
// Shared types, constants and elaboration-time sine helpers for the table
// sine tone generator.
// ----------------------------------------------------------------------------
package tstg_pkg;

    localparam int TABLE_ENTRIES_DEF = 100;
    localparam int CFG_W             = 18;
    localparam int SAMPLE_W          = 16;

    localparam logic [CFG_W-1:0] SAMPLE_RATE_RST = 18'd48000;
    localparam logic [CFG_W-1:0] TONE_FREQ_RST   = 18'd6000;

    // pi/2 in Q61 and the Q15 amplitude
    localparam logic [63:0] HALF_PI_Q61 = 64'd3622009729038561421;
    localparam logic [63:0] AMPL        = 64'd32767;

    typedef enum logic {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_TONE_FREQ   = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_DIV,
        ST_ROM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic phase_upd;
        logic prod_load;
        logic div_step;
        logic rom_rd;
        logic out_load;
    } dp_cmd_t;

    // (a * b) >> 61, kept to 64 bits
    function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[124:61];
    endfunction

    // trunc(32767 * sin(x)) for x in Q61, 0 < x < pi/2, by taylor series
    function automatic logic [63:0] sine_mag(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mul_q61(x, x);
        term = x;
        sum  = x;
        term = mul_q61(term, x2) / 64'd6;   sum = sum - term;
        term = mul_q61(term, x2) / 64'd20;  sum = sum + term;
        term = mul_q61(term, x2) / 64'd42;  sum = sum - term;
        term = mul_q61(term, x2) / 64'd72;  sum = sum + term;
        term = mul_q61(term, x2) / 64'd110; sum = sum - term;
        term = mul_q61(term, x2) / 64'd156; sum = sum + term;
        term = mul_q61(term, x2) / 64'd210; sum = sum - term;
        term = mul_q61(term, x2) / 64'd272; sum = sum + term;
        term = mul_q61(term, x2) / 64'd342; sum = sum - term;
        term = mul_q61(term, x2) / 64'd420; sum = sum + term;
        term = mul_q61(term, x2) / 64'd506; sum = sum - term;
        term = mul_q61(term, x2) / 64'd600; sum = sum + term;
        return ((sum >> 15) * AMPL) >> 46;
    endfunction

endpackage

// ===== src/table_sine_tone_generator.sv =====
// An accepted item passes through phase update, product, a serial divide that
// yields one index bit per cycle, table read and output load; s_ready stays low
// until the item is handed off, so no new item is taken before then.
// An item flagged overrun is taken and dropped and gives no result.
// Reset (aresetn low, synchronous) clears the phase to zero, the rate to 48000
// and the tone to 6000; the sine table is constant and needs no fill.
// ----------------------------------------------------------------------------
// table_sine_tone_generator
// Direct digital synthesis tone source: hertz phase accumulator, index
// divide by sample rate and a Q15 sine table, same sample on both channels.
// ----------------------------------------------------------------------------
module table_sine_tone_generator #(
    parameter int TABLE_ENTRIES = tstg_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_index,
    input  logic [tstg_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_overrun,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [tstg_pkg::SAMPLE_W-1:0] m_left_sample,
    output logic signed [tstg_pkg::SAMPLE_W-1:0] m_right_sample
);
    import tstg_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    dp_cmd_t                    cmd;
    logic signed [SAMPLE_W-1:0] sample;

    tstg_ctrl #(
        .IDX_W (IDX_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_overrun (s_overrun),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd)
    );

    tstg_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sample    (sample)
    );

    assign m_left_sample  = sample;
    assign m_right_sample = sample;

endmodule

// ===== src/tstg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// tstg_sine_rom
// Constant Q15 sine table, one full period, with a registered read port.
// ----------------------------------------------------------------------------
module tstg_sine_rom #(
    parameter int TABLE_ENTRIES = tstg_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_W        = $clog2(TABLE_ENTRIES)
) (
    input  logic                                aclk,
    input  logic                                rd_en,
    input  logic [ADDR_W-1:0]                   addr,
    output logic signed [tstg_pkg::SAMPLE_W-1:0] q
);
    import tstg_pkg::*;

    logic signed [SAMPLE_W-1:0] rom_word [TABLE_ENTRIES];
    logic signed [SAMPLE_W-1:0] q_reg;

    // entries built at elaboration by folding onto the first quarter wave
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
        localparam int unsigned T0  = 4 * i;
        localparam logic        NEG = (T0 >= 2 * TABLE_ENTRIES);
        localparam int unsigned T1  = NEG ? (T0 - 2 * TABLE_ENTRIES) : T0;
        localparam int unsigned T2  = (T1 > TABLE_ENTRIES) ? (2 * TABLE_ENTRIES - T1) : T1;
        localparam logic [63:0] XQ  = (HALF_PI_Q61 / TABLE_ENTRIES) * T2
                                    + ((HALF_PI_Q61 % TABLE_ENTRIES) * T2) / TABLE_ENTRIES;
        localparam logic [63:0] MAG = (T2 == 0) ? 64'd0 :
                                      ((T2 >= TABLE_ENTRIES) ? AMPL : sine_mag(XQ));
        localparam logic [SAMPLE_W-1:0] WORD = NEG ? (16'd0 - MAG[15:0]) : MAG[15:0];
        assign rom_word[i] = WORD;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            q_reg <= rom_word[addr];
        end
    end

    assign q = q_reg;

endmodule

// ===== src/tstg_datapath.sv =====
// ----------------------------------------------------------------------------
// tstg_datapath
// Config registers, phase accumulator, serial index divider, sine lookup
// and output sample register.
// ----------------------------------------------------------------------------
module tstg_datapath #(
    parameter int TABLE_ENTRIES = tstg_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_index,
    input  logic [tstg_pkg::CFG_W-1:0]           cfg_wdata,
    input  tstg_pkg::dp_cmd_t                    cmd,
    output logic signed [tstg_pkg::SAMPLE_W-1:0] sample
);
    import tstg_pkg::*;

    localparam int PROD_W = CFG_W + IDX_W;

    logic [CFG_W-1:0]           rate_reg;
    logic [CFG_W-1:0]           tone_reg;
    logic [CFG_W-1:0]           phase_reg;
    logic [CFG_W-1:0]           phase_next;
    logic [CFG_W-1:0]           rem_reg;
    logic [CFG_W-1:0]           rem_next;
    logic [IDX_W-1:0]           quo_reg;
    logic [IDX_W-1:0]           quo_next;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic [CFG_W-1:0]  rate_eff;
    logic [CFG_W-1:0]  tone_eff;
    logic [CFG_W:0]    sum;
    logic [CFG_W:0]    wrapped;
    logic [PROD_W-1:0] prod;
    logic [CFG_W:0]    trial;
    logic              trial_ge;
    logic [IDX_W-1:0]  rom_addr;
    logic signed [SAMPLE_W-1:0] rom_q;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= SAMPLE_RATE_RST;
            tone_reg <= TONE_FREQ_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SAMPLE_RATE: rate_reg <= cfg_wdata;
                CFG_TONE_FREQ:   tone_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // phase step: a zero rate acts as one, tone clamped below rate
    always_comb begin
        rate_eff = (rate_reg == '0) ? CFG_W'(1) : rate_reg;
        tone_eff = (tone_reg >= rate_eff) ? (rate_eff - CFG_W'(1)) : tone_reg;
        sum      = {1'b0, phase_reg} + {1'b0, tone_eff};
        wrapped  = (sum >= {1'b0, rate_eff}) ? (sum - {1'b0, rate_eff}) : sum;
        // still out of range only after the rate was lowered
        phase_next = (wrapped >= {1'b0, rate_eff}) ? '0 : wrapped[CFG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (cmd.phase_upd) begin
            phase_reg <= phase_next;
        end
    end

    // restoring divide of phase*entries by rate, one quotient bit a cycle
    always_comb begin
        prod     = PROD_W'(phase_reg) * PROD_W'(TABLE_ENTRIES);
        trial    = {rem_reg, quo_reg[IDX_W-1]};
        trial_ge = (trial >= {1'b0, rate_eff});
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.prod_load) begin
            rem_next = prod[PROD_W-1:IDX_W];
            quo_next = prod[IDX_W-1:0];
        end else if (cmd.div_step) begin
            rem_next = trial_ge ? CFG_W'(trial - {1'b0, rate_eff}) : trial[CFG_W-1:0];
            quo_next = {quo_reg[IDX_W-2:0], trial_ge};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rom_addr = ({1'b0, quo_reg} >= (IDX_W + 1)'(TABLE_ENTRIES)) ?
                      IDX_W'(TABLE_ENTRIES - 1) : quo_reg;

    tstg_sine_rom #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_W        (IDX_W)
    ) u_rom (
        .aclk  (aclk),
        .rd_en (cmd.rom_rd),
        .addr  (rom_addr),
        .q     (rom_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            sample_reg <= rom_q;
        end
    end

    assign sample = sample_reg;

endmodule

// ===== src/tstg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tstg_ctrl
// Sequencer for one item: phase update, product, serial divide, table read
// and hand-off to the output register.
// ----------------------------------------------------------------------------
module tstg_ctrl #(
    parameter int IDX_W = $clog2(tstg_pkg::TABLE_ENTRIES_DEF)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_overrun,
    output logic              m_valid,
    input  logic              m_ready,
    output tstg_pkg::dp_cmd_t cmd
);
    import tstg_pkg::*;

    localparam int CNT_W = $clog2(IDX_W + 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                // overrun items are taken and dropped
                if (s_valid && !s_overrun) begin
                    cmd.phase_upd = 1'b1;
                    state_next    = ST_PROD;
                end
            end
            ST_PROD: begin
                cmd.prod_load = 1'b1;
                cnt_next      = CNT_W'(IDX_W - 1);
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_ROM;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_ROM: begin
                cmd.rom_rd = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    assign m_valid = out_valid_reg;

endmodule
